// ----- rtl/mcsh_pkg.sv -----
// Shared constants, codes and control/status types of the context symbol histogram.
`timescale 1ns / 1ps
`default_nettype none

package mcsh_pkg;

    // Table geometry
    localparam int CTX_BITS   = 6;
    localparam int SYM_BITS   = 8;
    localparam int COUNT_BITS = 32;
    localparam int BIN_BITS   = CTX_BITS + SYM_BITS;
    localparam int NUM_CTX    = 1 << CTX_BITS;
    localparam int NUM_BINS   = 1 << BIN_BITS;

    // Word field widths on the channels
    localparam int OP_W     = 2;
    localparam int CTX_W    = 6;
    localparam int SYM_W    = 8;
    localparam int CNT_W    = 32;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
    localparam logic [OP_W-1:0] OP_INCR   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_CTX  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SYM  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_step;   // write one invalid entry of the clearing pass
        logic take;       // input side ready for a word
        logic wr_create;  // write the captured bin with its starting count
        logic rd_item;    // read the captured bin
        logic wr_incr;    // write back the incremented count if the bin exists
        logic scan_clear; // restart the symbol scan
        logic rd_scan;    // read the next symbol bin of the context
        logic res_load;   // load the output register
    } mcsh_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic            clr_last;
        logic            accepted;
        logic [OP_W-1:0] op;
        logic            scan_last;
        logic            out_free;
    } mcsh_stat_t;

endpackage

`default_nettype wire

// ----- rtl/mcsh_item_if.sv -----
// Input channel: one request word with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface mcsh_item_if import mcsh_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [CTX_W-1:0] context_req;
    logic [SYM_W-1:0] symbol;
    logic [CNT_W-1:0] start_count;

    modport source (output valid, output op, output context_req, output symbol,
                    output start_count, input ready);
    modport sink   (input valid, input op, input context_req, input symbol,
                    input start_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/mcsh_result_if.sv -----
// Output channel: one result word with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface mcsh_result_if import mcsh_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SYM_W-1:0]    freq_symbol;
    logic [CNT_W-1:0]    freq_count;

    modport source (output valid, output status, output freq_symbol,
                    output freq_count, input ready);
    modport sink   (input valid, input status, input freq_symbol,
                    input freq_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/markov_context_symbol_histogram.sv -----
// Top level of the Markov context/symbol count table with most-frequent lookup.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps one count per (context, symbol) bin in a 16384-entry memory
// with one read port and one write port, each entry holding a valid flag and
// the count. A create word marks a bin present and writes its starting count;
// an increment word raises an existing bin's count by one, saturating at full
// scale, or reports that the context or the symbol is absent; a query word
// walks all 256 symbol bins of one context and returns the largest count, ties
// going to the larger symbol. Every request word produces exactly one result
// word. After reset a clearing pass writes every memory entry invalid, one
// entry per cycle; no request word is taken until it finishes. Afterwards a
// create writes the captured bin, an increment does one memory read, then the
// write-back, and a query scans one symbol bin per cycle through the single
// memory read port, before the result is loaded.
// One request is worked on at a time. The next request is taken as soon as
// the result is in the output register, even if that result has not been
// taken yet; its own result then waits until the output register frees.

module markov_context_symbol_histogram import mcsh_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    mcsh_item_if.sink     item,
    mcsh_result_if.source result
);

    mcsh_cmd_t  cmd;
    mcsh_stat_t stat;

    // Sequence the operations
    mcsh_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Hold the table, scan logic and the output register
    mcsh_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .item   (item),
        .result (result)
    );

endmodule

`default_nettype wire

// ----- rtl/mcsh_ctrl.sv -----
// Sequencer for clearing, create, increment and query operations.
`timescale 1ns / 1ps
`default_nettype none

module mcsh_ctrl import mcsh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  mcsh_stat_t stat,
    output mcsh_cmd_t  cmd
);

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_DISPATCH = 3'd2;
    localparam logic [2:0] S_INC_WAIT = 3'd3;
    localparam logic [2:0] S_SCAN     = 3'd4;
    localparam logic [2:0] S_TAIL     = 3'd5;
    localparam logic [2:0] S_FINISH   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.take = 1'b1;
                if (stat.accepted)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.op)
                    OP_CREATE:
                    begin
                        cmd.wr_create = 1'b1;
                        state_next    = S_FINISH;
                    end
                    OP_INCR:
                    begin
                        cmd.rd_item = 1'b1;
                        state_next  = S_INC_WAIT;
                    end
                    OP_QUERY:
                    begin
                        cmd.scan_clear = 1'b1;
                        state_next     = S_SCAN;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_INC_WAIT:
            begin
                cmd.wr_incr = 1'b1;
                state_next  = S_FINISH;
            end
            S_SCAN:
            begin
                cmd.rd_scan = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mcsh_dp.sv -----
// Datapath: bin memory, context flags, scan/argmax logic and output register.
`timescale 1ns / 1ps
`default_nettype none

module mcsh_dp import mcsh_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  mcsh_cmd_t     cmd,
    output mcsh_stat_t    stat,
    mcsh_item_if.sink     item,
    mcsh_result_if.source result
);

    // Each entry: valid flag on top, count below
    logic [COUNT_BITS:0] bin_mem [NUM_BINS];

    logic [BIN_BITS-1:0]   clr_addr_reg, clr_addr_next;
    logic [NUM_CTX-1:0]    ctx_valid_reg, ctx_valid_next;
    logic [OP_W-1:0]       op_reg;
    logic [CTX_BITS-1:0]   ctx_reg;
    logic [SYM_BITS-1:0]   sym_reg;
    logic [COUNT_BITS-1:0] start_reg;
    logic [COUNT_BITS:0]   rd_data_reg;
    logic [SYM_BITS-1:0]   scan_sym_reg, scan_sym_next;
    logic [SYM_BITS-1:0]   cmp_sym_reg, cmp_sym_next;
    logic                  pipe_reg, pipe_next;
    logic                  best_found_reg, best_found_next;
    logic [SYM_BITS-1:0]   best_sym_reg, best_sym_next;
    logic [COUNT_BITS-1:0] best_cnt_reg, best_cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [SYM_BITS-1:0]   out_sym_reg;
    logic [COUNT_BITS-1:0] out_cnt_reg;

    logic                  accepted;
    logic [BIN_BITS-1:0]   item_addr;
    logic [BIN_BITS-1:0]   rd_addr;
    logic [BIN_BITS-1:0]   wr_addr;
    logic [COUNT_BITS:0]   wr_data;
    logic                  mem_we;
    logic                  mem_re;
    logic                  rd_bin_valid;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [COUNT_BITS-1:0] inc_cnt;
    logic                  hit;
    logic [STATUS_W-1:0]   res_status;
    logic [SYM_BITS-1:0]   res_sym;
    logic [COUNT_BITS-1:0] res_cnt;

    assign item.ready = cmd.take;
    assign accepted   = item.valid && cmd.take;

    assign item_addr    = {ctx_reg, sym_reg};
    assign rd_bin_valid = rd_data_reg[COUNT_BITS];
    assign rd_cnt       = rd_data_reg[COUNT_BITS-1:0];
    assign inc_cnt      = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;
    assign hit          = rd_bin_valid && (!best_found_reg || rd_cnt >= best_cnt_reg);

    // Memory port selection
    always_comb
    begin
        rd_addr = cmd.rd_scan ? {ctx_reg, scan_sym_reg} : item_addr;
        mem_re  = cmd.rd_scan || cmd.rd_item;
        mem_we  = cmd.clr_step || cmd.wr_create || (cmd.wr_incr && rd_bin_valid);
        wr_addr = cmd.clr_step ? clr_addr_reg : item_addr;
        if (cmd.clr_step)
        begin
            wr_data = '0;
        end
        else if (cmd.wr_create)
        begin
            wr_data = {1'b1, start_reg};
        end
        else
        begin
            wr_data = {1'b1, inc_cnt};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bin_mem[wr_addr] <= wr_data;
        end
        if (mem_re)
        begin
            rd_data_reg <= bin_mem[rd_addr];
        end
    end

    // Result selection by operation
    always_comb
    begin
        res_status = ST_OK;
        res_sym    = '0;
        res_cnt    = '0;
        case (op_reg)
            OP_CREATE:
            begin
                res_sym = sym_reg;
                res_cnt = start_reg;
            end
            OP_INCR:
            begin
                if (!ctx_valid_reg[ctx_reg])
                begin
                    res_status = ST_NO_CTX;
                end
                else if (!rd_bin_valid)
                begin
                    res_status = ST_NO_SYM;
                end
                else
                begin
                    res_sym = sym_reg;
                    res_cnt = inc_cnt;
                end
            end
            OP_QUERY:
            begin
                if (best_found_reg)
                begin
                    res_sym = best_sym_reg;
                    res_cnt = best_cnt_reg;
                end
                else
                begin
                    res_status = ST_NO_CTX;
                end
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    // Next-state logic for control registers
    always_comb
    begin
        clr_addr_next  = cmd.clr_step ? clr_addr_reg + 1'b1 : clr_addr_reg;
        ctx_valid_next = ctx_valid_reg;
        if (cmd.wr_create)
        begin
            ctx_valid_next[ctx_reg] = 1'b1;
        end

        scan_sym_next = scan_sym_reg;
        cmp_sym_next  = cmp_sym_reg;
        if (cmd.scan_clear)
        begin
            scan_sym_next = '0;
        end
        else if (cmd.rd_scan)
        begin
            scan_sym_next = scan_sym_reg + 1'b1;
            cmp_sym_next  = scan_sym_reg;
        end
        pipe_next = cmd.rd_scan;

        best_found_next = best_found_reg;
        best_sym_next   = best_sym_reg;
        best_cnt_next   = best_cnt_reg;
        if (cmd.scan_clear)
        begin
            best_found_next = 1'b0;
        end
        else if (pipe_reg && hit)
        begin
            best_found_next = 1'b1;
            best_sym_next   = cmp_sym_reg;
            best_cnt_next   = rd_cnt;
        end

        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg   <= '0;
            ctx_valid_reg  <= '0;
            pipe_reg       <= 1'b0;
            best_found_reg <= 1'b0;
            scan_sym_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            clr_addr_reg   <= clr_addr_next;
            ctx_valid_reg  <= ctx_valid_next;
            pipe_reg       <= pipe_next;
            best_found_reg <= best_found_next;
            scan_sym_reg   <= scan_sym_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accepted)
        begin
            op_reg    <= item.op;
            ctx_reg   <= CTX_BITS'(item.context_req);
            sym_reg   <= SYM_BITS'(item.symbol);
            start_reg <= COUNT_BITS'(item.start_count);
        end
        cmp_sym_reg  <= cmp_sym_next;
        best_sym_reg <= best_sym_next;
        best_cnt_reg <= best_cnt_next;
        if (cmd.res_load)
        begin
            out_status_reg <= res_status;
            out_sym_reg    <= res_sym;
            out_cnt_reg    <= res_cnt;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.status      = out_status_reg;
    assign result.freq_symbol = SYM_W'(out_sym_reg);
    assign result.freq_count  = CNT_W'(out_cnt_reg);

    assign stat.clr_last  = (clr_addr_reg == '1);
    assign stat.accepted  = accepted;
    assign stat.op        = op_reg;
    assign stat.scan_last = (scan_sym_reg == '1);
    assign stat.out_free  = !out_valid_reg || result.ready;

    // The clearing pass never overlaps with taking words
    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_step |-> !item.ready)
        else $error("input taken during clearing pass");

    // A new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> !(out_valid_reg && !result.ready))
        else $error("result register overwritten");

    // Output valid rises only after a result load
    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.res_load))
        else $error("output valid without result load");

    // A scan hit always marks the best as found
    a_found_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (pipe_reg && hit && !cmd.scan_clear) |=> best_found_reg)
        else $error("scan hit lost");

endmodule

`default_nettype wire
